// ===== sv/dca_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and calendar tables for the date arithmetic core
package dca_pkg;

  // largest result year of an add or subtract
  localparam int MAX_YEAR = 9999;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 56;

  localparam int Y_W   = 16;        // working year, holds any year up to MAX_YEAR
  localparam int N_W   = 26;        // day serial, two's complement
  localparam int R_W   = N_W - 1;   // remainder while splitting a serial
  localparam int Q_W   = 10;        // year / 100
  localparam int PC_W  = 5;
  localparam int CNT_W = 23;

  // year / 100 as (year * RECIP_100) >> RECIP_SH, exact for years below 199728
  localparam int RECIP_W   = 18;
  localparam int RECIP_100 = 167773;
  localparam int RECIP_SH  = 24;

  // days in 400, 100, 4 and 1 years
  localparam logic [R_W-1:0] D400 = R_W'(146097);
  localparam logic [R_W-1:0] D100 = R_W'(36524);
  localparam logic [R_W-1:0] D4   = R_W'(1461);
  localparam logic [R_W-1:0] D1   = R_W'(365);

  // serial of the first day after year MAX_YEAR
  localparam int LIMIT = MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400;

  localparam int DIFF_MAX = 4194303;
  localparam int DIFF_MIN = -4194304;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_SUB  = 2'd1,
    OP_DIFF = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    UOP_NOP,
    UOP_LOAD_A,
    UOP_LOAD_B,
    UOP_DIV,
    UOP_LEAP,
    UOP_SER1,
    UOP_SER2,
    UOP_SAVE_A,
    UOP_ADDCNT,
    UOP_RANGE,
    UOP_INIT_FS,
    UOP_Q400,
    UOP_Q100,
    UOP_Q4,
    UOP_Q1,
    UOP_MONTH,
    UOP_SET_DATE,
    UOP_DIFF,
    UOP_DONE
  } uop_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_GUARD,
    COND_OP_DIFF,
    COND_SKIP_ADD,
    COND_INVALID,
    COND_OUT_RANGE
  } cond_t;

  // program addresses that are jump targets
  localparam logic [PC_W-1:0] ST_Q400   = PC_W'(10);
  localparam logic [PC_W-1:0] ST_Q100   = PC_W'(11);
  localparam logic [PC_W-1:0] ST_Q4     = PC_W'(12);
  localparam logic [PC_W-1:0] ST_Q1     = PC_W'(13);
  localparam logic [PC_W-1:0] ST_MONTH  = PC_W'(16);
  localparam logic [PC_W-1:0] ST_DIFF   = PC_W'(18);
  localparam logic [PC_W-1:0] ST_FINISH = PC_W'(26);

  typedef struct packed {
    uop_t            uop;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic guard;
    logic vld;
    logic out_range;
    logic op_diff;
    logic skip_add;
  } stat_t;

  typedef struct packed {
    op_t              op;
    logic [13:0]      year_a;
    logic [3:0]       month_a;
    logic [4:0]       day_a;
    logic [13:0]      year_b;
    logic [3:0]       month_b;
    logic [4:0]       day_b;
    logic [CNT_W-1:0] day_count;
  } in_t;

  typedef struct packed {
    logic [13:0]      year_out;
    logic [3:0]       month_out;
    logic [4:0]       day_out;
    logic [CNT_W-1:0] day_difference;
    logic             a_less_than_b;
    logic             a_equals_b;
    logic             a_is_valid;
    logic             range_error;
  } res_t;

  function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   n = 5'd30;
      4'd2:                                      n = leap ? 5'd29 : 5'd28;
      default:                                   n = 5'd0;
    endcase
    return n;
  endfunction

  // days before the first of a month in a common year
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] n;
    unique case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== sv/dca_urom.sv =====
`timescale 1ns / 1ps
// control store of the date sequencer
module dca_urom import dca_pkg::*; (
  input  logic [PC_W-1:0] pc,
  output ctrl_t           word
);

  function automatic ctrl_t cw(input uop_t u, input cond_t c, input logic [PC_W-1:0] t);
    ctrl_t w;
    w.uop    = u;
    w.cond   = c;
    w.target = t;
    return w;
  endfunction

  always_comb begin
    unique case (pc)
      // serial of date A
      5'd0:  word = cw(UOP_LOAD_A,   COND_NEXT,      '0);
      5'd1:  word = cw(UOP_DIV,      COND_NEXT,      '0);
      5'd2:  word = cw(UOP_LEAP,     COND_NEXT,      '0);
      5'd3:  word = cw(UOP_SER1,     COND_NEXT,      '0);
      5'd4:  word = cw(UOP_SER2,     COND_NEXT,      '0);
      5'd5:  word = cw(UOP_SAVE_A,   COND_OP_DIFF,   ST_DIFF);
      // add or subtract
      5'd6:  word = cw(UOP_NOP,      COND_SKIP_ADD,  ST_FINISH);
      5'd7:  word = cw(UOP_ADDCNT,   COND_NEXT,      '0);
      5'd8:  word = cw(UOP_RANGE,    COND_OUT_RANGE, ST_FINISH);
      5'd9:  word = cw(UOP_INIT_FS,  COND_NEXT,      '0);
      5'd10: word = cw(UOP_Q400,     COND_GUARD,     ST_Q400);
      5'd11: word = cw(UOP_Q100,     COND_GUARD,     ST_Q100);
      5'd12: word = cw(UOP_Q4,       COND_GUARD,     ST_Q4);
      5'd13: word = cw(UOP_Q1,       COND_GUARD,     ST_Q1);
      5'd14: word = cw(UOP_DIV,      COND_NEXT,      '0);
      5'd15: word = cw(UOP_LEAP,     COND_NEXT,      '0);
      5'd16: word = cw(UOP_MONTH,    COND_GUARD,     ST_MONTH);
      5'd17: word = cw(UOP_SET_DATE, COND_ALWAYS,    ST_FINISH);
      // difference, serial of date B
      5'd18: word = cw(UOP_NOP,      COND_INVALID,   ST_FINISH);
      5'd19: word = cw(UOP_LOAD_B,   COND_NEXT,      '0);
      5'd20: word = cw(UOP_DIV,      COND_NEXT,      '0);
      5'd21: word = cw(UOP_LEAP,     COND_NEXT,      '0);
      5'd22: word = cw(UOP_SER1,     COND_NEXT,      '0);
      5'd23: word = cw(UOP_SER2,     COND_NEXT,      '0);
      5'd24: word = cw(UOP_NOP,      COND_INVALID,   ST_FINISH);
      5'd25: word = cw(UOP_DIFF,     COND_NEXT,      '0);
      default: word = cw(UOP_DONE,   COND_NEXT,      '0);
    endcase
  end

endmodule

// ===== sv/dca_useq.sv =====
`timescale 1ns / 1ps
// step counter and branch logic of the date sequencer
module dca_useq import dca_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  out_free,
  input  stat_t stat,
  output logic  busy,
  output logic  done,
  output ctrl_t ctrl
);

  logic [PC_W-1:0] pc;
  logic            take;

  dca_urom u_urom (
    .pc   (pc),
    .word (ctrl)
  );

  always_comb begin
    unique case (ctrl.cond)
      COND_NEXT:      take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_GUARD:     take = stat.guard;
      COND_OP_DIFF:   take = stat.op_diff;
      COND_SKIP_ADD:  take = stat.skip_add;
      COND_INVALID:   take = !stat.vld;
      COND_OUT_RANGE: take = stat.out_range;
      default:        take = 1'b0;
    endcase
  end

  assign done = busy && (ctrl.uop == UOP_DONE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
    end else if (start) begin
      busy <= 1'b1;
      pc   <= '0;
    end else if (busy) begin
      if (ctrl.uop == UOP_DONE) begin
        // hold on the last step until the output register is free
        if (out_free) begin
          busy <= 1'b0;
        end
      end else begin
        pc <= take ? ctrl.target : pc + PC_W'(1);
      end
    end
  end

endmodule

// ===== sv/dca_dpath.sv =====
`timescale 1ns / 1ps
// datapath of the date core: serial conversion, add, split and difference
module dca_dpath import dca_pkg::*; (
  input  logic  clk,
  input  logic  load,
  input  in_t   item,
  input  logic  run,
  input  ctrl_t ctrl,
  output stat_t stat,
  output res_t  res
);

  in_t              inr;
  logic [Y_W-1:0]   y;
  logic [3:0]       m;
  logic [4:0]       d;
  logic [Q_W-1:0]   qy;
  logic [Q_W-1:0]   qp;
  logic             leap;
  logic             vld;
  logic [N_W-1:0]   acc;
  logic [N_W-1:0]   sa;
  logic [R_W-1:0]   r;
  logic [1:0]       kc;

  logic [Y_W-1:0]                 p;
  logic [Y_W+RECIP_W-1:0]         prod_y;
  logic [Y_W+RECIP_W-1:0]         prod_p;
  logic [Y_W:0]                   hund;
  logic                           y_cent;
  logic                           leap_n;
  logic [4:0]                     dim;
  logic                           date_ok;
  logic [N_W-1:0]                 cnt_ext;
  logic [N_W:0]                   dwide;
  logic [CNT_W-1:0]               dsat;
  logic                           less_n;
  logic                           eq_n;
  logic                           guard_n;

  assign p      = y - Y_W'(1);
  assign prod_y = (Y_W+RECIP_W)'(y) * (Y_W+RECIP_W)'(RECIP_100);
  assign prod_p = (Y_W+RECIP_W)'(p) * (Y_W+RECIP_W)'(RECIP_100);

  assign hund   = (Y_W+1)'(qy) * (Y_W+1)'(100);
  assign y_cent = ({1'b0, y} == hund);
  assign leap_n = ((y[1:0] == 2'b00) && !y_cent) || (y_cent && (qy[1:0] == 2'b00));

  assign dim     = days_in_month(m, leap);
  assign date_ok = (y != '0) && (m >= 4'd1) && (m <= 4'd12) && (d >= 5'd1) && (d <= dim);

  assign cnt_ext = {{(N_W-CNT_W){inr.day_count[CNT_W-1]}}, inr.day_count};

  assign dwide = {sa[N_W-1], sa} - {acc[N_W-1], acc};
  always_comb begin
    if ($signed(dwide) > $signed((N_W+1)'(DIFF_MAX))) begin
      dsat = CNT_W'(DIFF_MAX);
    end else if ($signed(dwide) < $signed((N_W+1)'(DIFF_MIN))) begin
      dsat = CNT_W'(DIFF_MIN);
    end else begin
      dsat = dwide[CNT_W-1:0];
    end
  end

  // raw field compare, legal or not
  assign less_n = {inr.year_a, inr.month_a, inr.day_a} < {inr.year_b, inr.month_b, inr.day_b};
  assign eq_n   = {inr.year_a, inr.month_a, inr.day_a} == {inr.year_b, inr.month_b, inr.day_b};

  always_comb begin
    unique case (ctrl.uop)
      UOP_Q400:  guard_n = (r >= D400);
      UOP_Q100:  guard_n = (r >= D100) && (kc != 2'd3);
      UOP_Q4:    guard_n = (r >= D4);
      UOP_Q1:    guard_n = (r >= D1) && (kc != 2'd3);
      UOP_MONTH: guard_n = (m < 4'd12) && (r >= R_W'(dim));
      default:   guard_n = 1'b0;
    endcase
  end

  assign stat.guard     = guard_n;
  assign stat.vld       = vld;
  // negative serials read as huge unsigned values, so one compare covers both ends
  assign stat.out_range = (acc >= N_W'(LIMIT));
  assign stat.op_diff   = (inr.op == OP_DIFF);
  assign stat.skip_add  = (inr.op == OP_NONE) || !vld;

  always_ff @(posedge clk) begin
    if (load) begin
      inr <= item;
    end
    if (run) begin
      unique case (ctrl.uop)
        UOP_LOAD_A: begin
          y                  <= Y_W'(inr.year_a);
          m                  <= inr.month_a;
          d                  <= inr.day_a;
          res.year_out       <= inr.year_a;
          res.month_out      <= inr.month_a;
          res.day_out        <= inr.day_a;
          res.day_difference <= '0;
          res.range_error    <= 1'b0;
          res.a_less_than_b  <= less_n;
          res.a_equals_b     <= eq_n;
        end
        UOP_LOAD_B: begin
          y <= Y_W'(inr.year_b);
          m <= inr.month_b;
          d <= inr.day_b;
        end
        UOP_DIV: begin
          qy <= prod_y[RECIP_SH +: Q_W];
          qp <= prod_p[RECIP_SH +: Q_W];
        end
        UOP_LEAP: begin
          leap <= leap_n;
        end
        UOP_SER1: begin
          acc <= N_W'(p) * N_W'(365) + N_W'(p >> 2);
          vld <= date_ok;
        end
        UOP_SER2: begin
          // (y-1)/400 is floor of (y-1)/100 over four
          acc <= acc - N_W'(qp) + N_W'(qp >> 2) + N_W'(days_before(m))
                 + N_W'(leap && (m > 4'd2)) + N_W'(d) - N_W'(1);
        end
        UOP_SAVE_A: begin
          sa             <= acc;
          res.a_is_valid <= vld;
        end
        UOP_ADDCNT: begin
          acc <= (inr.op == OP_SUB) ? acc - cnt_ext : acc + cnt_ext;
        end
        UOP_RANGE: begin
          res.range_error <= stat.out_range;
        end
        UOP_INIT_FS: begin
          r <= acc[R_W-1:0];
          y <= Y_W'(1);
          m <= 4'd1;
        end
        UOP_Q400: begin
          kc <= 2'd0;
          if (stat.guard) begin
            r <= r - D400;
            y <= y + Y_W'(400);
          end
        end
        UOP_Q100: begin
          if (stat.guard) begin
            r  <= r - D100;
            y  <= y + Y_W'(100);
            kc <= kc + 2'd1;
          end
        end
        UOP_Q4: begin
          kc <= 2'd0;
          if (stat.guard) begin
            r <= r - D4;
            y <= y + Y_W'(4);
          end
        end
        UOP_Q1: begin
          if (stat.guard) begin
            r  <= r - D1;
            y  <= y + Y_W'(1);
            kc <= kc + 2'd1;
          end
        end
        UOP_MONTH: begin
          if (stat.guard) begin
            r <= r - R_W'(dim);
            m <= m + 4'd1;
          end
        end
        UOP_SET_DATE: begin
          res.year_out  <= y[13:0];
          res.month_out <= m;
          res.day_out   <= r[4:0] + 5'd1;
        end
        UOP_DIFF: begin
          res.day_difference <= dsat;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sv/calendar_date_arithmetic_core.sv =====
`timescale 1ns / 1ps
// Gregorian date core: add or subtract days, or the day difference of two dates.
// run time differs for a difference (shorter with an illegal date B), an illegal A or the
// unused op, a shift that leaves the year range, and an add or subtract, where it is set
// by the year and month loops of the microcoded sequencer; a stalled output adds its wait.
// one item at a time: the next is taken the cycle after its result reaches the output register.
// synchronous active-high reset clears the sequencer and the output valid.
module calendar_date_arithmetic_core import dca_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // year_a, month_a, day_a, year_b, month_b, day_b, day_count, zero pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // op
  input  logic [1:0]             s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // year_out, month_out, day_out, day_difference, a_less_than_b, a_equals_b,
  // a_is_valid, range_error, zero pad
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  logic  accept;
  logic  busy;
  logic  done;
  logic  out_free;
  in_t   item;
  ctrl_t ctrl;
  stat_t stat;
  res_t  res;

  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign item.op        = op_t'(s_tuser);
  assign item.year_a    = s_tdata[13:0];
  assign item.month_a   = s_tdata[17:14];
  assign item.day_a     = s_tdata[22:18];
  assign item.year_b    = s_tdata[36:23];
  assign item.month_b   = s_tdata[40:37];
  assign item.day_b     = s_tdata[45:41];
  assign item.day_count = s_tdata[68:46];

  dca_useq u_useq (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .out_free (out_free),
    .stat     (stat),
    .busy     (busy),
    .done     (done),
    .ctrl     (ctrl)
  );

  dca_dpath u_dpath (
    .clk  (clk),
    .load (accept),
    .item (item),
    .run  (busy),
    .ctrl (ctrl),
    .stat (stat),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      m_tdata <= {(OUT_TDATA_W-50)'(0), res.range_error, res.a_is_valid, res.a_equals_b,
                  res.a_less_than_b, res.day_difference, res.day_out, res.month_out,
                  res.year_out};
    end
  end

`ifndef NO_ASSERTIONS
  a_no_accept_busy : assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_tready)
    else $error("input taken while an item is in work");

  a_result_from_work : assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(busy))
    else $error("result appeared with no item in work");

  a_valid_month : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[48]) |->
      (m_tdata[17:14] >= 4'd1 && m_tdata[17:14] <= 4'd12 && m_tdata[22:18] != 5'd0))
    else $error("illegal result date for a legal date A");

  a_diff_needs_valid : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[45:23] != '0) |-> m_tdata[48])
    else $error("day difference reported for an illegal date A");
`endif

endmodule
